[src/sgi2d_pkg.sv]
// Package for the 2D segment intersection core: coordinate width, derived
// arithmetic widths, status codes and the request and result payload types.
// No dependencies.
package sgi2d_pkg;

	// Width of one signed coordinate.
	localparam int COORD_WIDTH = 16;

	// Derived widths of the intermediate terms, all exact.
	localparam int DIFF_W  = COORD_WIDTH + 1;       // a1, b1, a2, b2
	localparam int PROD_W  = 2 * COORD_WIDTH + 1;   // c terms and coordinate products
	localparam int DEN_W   = 2 * COORD_WIDTH + 3;   // denominator and side values
	localparam int NUM_W   = 3 * COORD_WIDTH + 3;   // crossing numerators
	localparam int ADJ_W   = 3 * COORD_WIDTH + 4;   // rounded numerator magnitude
	localparam int QUOT_W  = COORD_WIDTH + 1;       // quotient magnitude

	// Status codes.
	localparam logic [1:0] STATUS_NONE      = 2'd0;
	localparam logic [1:0] STATUS_COLLINEAR = 2'd1;
	localparam logic [1:0] STATUS_CROSS     = 2'd2;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] a_start_x;
		logic signed [COORD_WIDTH-1:0] a_start_y;
		logic signed [COORD_WIDTH-1:0] a_end_x;
		logic signed [COORD_WIDTH-1:0] a_end_y;
		logic signed [COORD_WIDTH-1:0] b_start_x;
		logic signed [COORD_WIDTH-1:0] b_start_y;
		logic signed [COORD_WIDTH-1:0] b_end_x;
		logic signed [COORD_WIDTH-1:0] b_end_y;
	} seg_pair_t;

	typedef struct packed {
		logic        [1:0]             status;
		logic signed [COORD_WIDTH-1:0] cross_x;
		logic signed [COORD_WIDTH-1:0] cross_y;
	} seg_result_t;

endpackage

[src/segment_intersection_2d_core.sv]
// Pipelined 2D line segment intersection core, top level.
// Depends on sgi2d_pkg for widths, status codes and payload types.
//
// The core accepts one segment pair per clock cycle while the output is not
// stalled, and returns one result per pair, in order.
// Six arithmetic stages build the line equations, the side tests, the
// denominator and the rounded numerators; a restoring divider of
// COORD_WIDTH + 1 stages, one quotient bit per stage, then gives the
// crossing point, and a final output register holds the result. The whole
// pipeline advances together whenever the output register is empty or its
// result is being taken, so a stall at the output holds every stage in place.
// The crossing coordinates read 0 unless the status is intersect.
module segment_intersection_2d_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  sgi2d_pkg::seg_pair_t in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output sgi2d_pkg::seg_result_t out_data
);
	import sgi2d_pkg::*;

	localparam int W = COORD_WIDTH;

	logic en;

	// Stage 1: coordinates and line direction terms.
	logic                     v_s1;
	logic signed [W-1:0]      x1_s1, y1_s1, x2_s1, y2_s1, x3_s1, y3_s1, x4_s1, y4_s1;
	logic signed [DIFF_W-1:0] a1_s1, b1_s1, a2_s1, b2_s1;

	// Stage 2: all first-level products.
	logic                     v_s2;
	logic signed [DIFF_W-1:0] a1_s2, b1_s2, a2_s2, b2_s2;
	logic signed [PROD_W-1:0] x2y1_s2, x1y2_s2, x4y3_s2, x3y4_s2;
	logic signed [PROD_W-1:0] a1x3_s2, b1y3_s2, a1x4_s2, b1y4_s2;
	logic signed [PROD_W-1:0] a2x1_s2, b2y1_s2, a2x2_s2, b2y2_s2;
	logic signed [DEN_W-1:0]  a1b2_s2, a2b1_s2;

	// Stage 3: constant terms, partial side sums and the denominator.
	logic                     v_s3;
	logic signed [DIFF_W-1:0] a1_s3, b1_s3, a2_s3, b2_s3;
	logic signed [PROD_W-1:0] c1_s3, c2_s3;
	logic signed [DEN_W-1:0]  t1_s3, t2_s3, t3_s3, t4_s3, den_s3;

	// Stage 4: side test outcome and numerator products.
	logic                     v_s4;
	logic                     reject_s4, den_zero_s4;
	logic signed [DEN_W-1:0]  den_s4;
	logic signed [NUM_W-1:0]  b1c2_s4, b2c1_s4, a2c1_s4, a1c2_s4;

	// Stage 5: numerators, status and rounding offset.
	logic                     v_s5;
	logic [1:0]               status_s5;
	logic signed [NUM_W-1:0]  numx_s5, numy_s5;
	logic                     den_neg_s5;
	logic [DEN_W-1:0]         den_mag_s5;

	// Divider pipeline; entry 0 is loaded from stage 5 with the rounded numerators.
	logic                dv_v_s      [0:W+1];
	logic [1:0]          dv_status_s [0:W+1];
	logic [DEN_W-1:0]    dv_dm_s     [0:W+1];
	logic                dvx_neg_s   [0:W+1];
	logic                dvy_neg_s   [0:W+1];
	logic [ADJ_W-1:0]    dvx_rem_s   [0:W+1];
	logic [ADJ_W-1:0]    dvy_rem_s   [0:W+1];
	logic [QUOT_W-1:0]   dvx_q_s     [0:W+1];
	logic [QUOT_W-1:0]   dvy_q_s     [0:W+1];

	logic                v_out_q;
	seg_result_t         out_q;

	// The pipeline moves as one whenever the output can take a new result.
	assign en        = !v_out_q || out_ready;
	assign in_ready  = en;
	assign out_valid = v_out_q;
	assign out_data  = out_q;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_out_q <= 1'b0;
			for (int i = 0; i <= W + 1; i++) begin
				dv_v_s[i] <= 1'b0;
			end
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s5      <= v_s4;
			dv_v_s[0] <= v_s5;
			for (int i = 0; i <= W; i++) begin
				dv_v_s[i+1] <= dv_v_s[i];
			end
			v_out_q   <= dv_v_s[W+1];
		end
	end

	// Stage 1: register the endpoints and form the direction differences.
	always_ff @(posedge clk) begin
		if (en) begin
			x1_s1 <= in_data.a_start_x;
			y1_s1 <= in_data.a_start_y;
			x2_s1 <= in_data.a_end_x;
			y2_s1 <= in_data.a_end_y;
			x3_s1 <= in_data.b_start_x;
			y3_s1 <= in_data.b_start_y;
			x4_s1 <= in_data.b_end_x;
			y4_s1 <= in_data.b_end_y;
			a1_s1 <= DIFF_W'(in_data.a_end_y)   - DIFF_W'(in_data.a_start_y);
			b1_s1 <= DIFF_W'(in_data.a_start_x) - DIFF_W'(in_data.a_end_x);
			a2_s1 <= DIFF_W'(in_data.b_end_y)   - DIFF_W'(in_data.b_start_y);
			b2_s1 <= DIFF_W'(in_data.b_start_x) - DIFF_W'(in_data.b_end_x);
		end
	end

	// Stage 2: one multiplier per product, all in parallel.
	always_ff @(posedge clk) begin
		if (en) begin
			a1_s2   <= a1_s1;
			b1_s2   <= b1_s1;
			a2_s2   <= a2_s1;
			b2_s2   <= b2_s1;
			x2y1_s2 <= PROD_W'(x2_s1) * PROD_W'(y1_s1);
			x1y2_s2 <= PROD_W'(x1_s1) * PROD_W'(y2_s1);
			x4y3_s2 <= PROD_W'(x4_s1) * PROD_W'(y3_s1);
			x3y4_s2 <= PROD_W'(x3_s1) * PROD_W'(y4_s1);
			a1x3_s2 <= PROD_W'(a1_s1) * PROD_W'(x3_s1);
			b1y3_s2 <= PROD_W'(b1_s1) * PROD_W'(y3_s1);
			a1x4_s2 <= PROD_W'(a1_s1) * PROD_W'(x4_s1);
			b1y4_s2 <= PROD_W'(b1_s1) * PROD_W'(y4_s1);
			a2x1_s2 <= PROD_W'(a2_s1) * PROD_W'(x1_s1);
			b2y1_s2 <= PROD_W'(b2_s1) * PROD_W'(y1_s1);
			a2x2_s2 <= PROD_W'(a2_s1) * PROD_W'(x2_s1);
			b2y2_s2 <= PROD_W'(b2_s1) * PROD_W'(y2_s1);
			a1b2_s2 <= DEN_W'(a1_s1) * DEN_W'(b2_s1);
			a2b1_s2 <= DEN_W'(a2_s1) * DEN_W'(b1_s1);
		end
	end

	// Stage 3: line constants, partial side values and the denominator.
	always_ff @(posedge clk) begin
		if (en) begin
			a1_s3  <= a1_s2;
			b1_s3  <= b1_s2;
			a2_s3  <= a2_s2;
			b2_s3  <= b2_s2;
			c1_s3  <= x2y1_s2 - x1y2_s2;
			c2_s3  <= x4y3_s2 - x3y4_s2;
			t3_s3  <= DEN_W'(a1x3_s2) + DEN_W'(b1y3_s2);
			t4_s3  <= DEN_W'(a1x4_s2) + DEN_W'(b1y4_s2);
			t1_s3  <= DEN_W'(a2x1_s2) + DEN_W'(b2y1_s2);
			t2_s3  <= DEN_W'(a2x2_s2) + DEN_W'(b2y2_s2);
			den_s3 <= a1b2_s2 - a2b1_s2;
		end
	end

	// Stage 4 side values: both ends strictly on one side rejects the pair.
	logic signed [DEN_W-1:0] s1_c, s2_c, s3_c, s4_c;
	logic                    same_a_c, same_b_c;

	always_comb begin
		s1_c     = t1_s3 + DEN_W'(c2_s3);
		s2_c     = t2_s3 + DEN_W'(c2_s3);
		s3_c     = t3_s3 + DEN_W'(c1_s3);
		s4_c     = t4_s3 + DEN_W'(c1_s3);
		same_a_c = (s3_c != '0) && (s4_c != '0) && (s3_c[DEN_W-1] == s4_c[DEN_W-1]);
		same_b_c = (s1_c != '0) && (s2_c != '0) && (s1_c[DEN_W-1] == s2_c[DEN_W-1]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			reject_s4   <= same_a_c || same_b_c;
			den_zero_s4 <= (den_s3 == '0);
			den_s4      <= den_s3;
			b1c2_s4     <= NUM_W'(b1_s3) * NUM_W'(c2_s3);
			b2c1_s4     <= NUM_W'(b2_s3) * NUM_W'(c1_s3);
			a2c1_s4     <= NUM_W'(a2_s3) * NUM_W'(c1_s3);
			a1c2_s4     <= NUM_W'(a1_s3) * NUM_W'(c2_s3);
		end
	end

	// Stage 5: numerators, status and the denominator magnitude.
	always_ff @(posedge clk) begin
		if (en) begin
			numx_s5    <= b1c2_s4 - b2c1_s4;
			numy_s5    <= a2c1_s4 - a1c2_s4;
			den_neg_s5 <= den_s4[DEN_W-1];
			den_mag_s5 <= den_s4[DEN_W-1] ? DEN_W'(-den_s4) : DEN_W'(den_s4);
			if (reject_s4) begin
				status_s5 <= STATUS_NONE;
			end else if (den_zero_s4) begin
				status_s5 <= STATUS_COLLINEAR;
			end else begin
				status_s5 <= STATUS_CROSS;
			end
		end
	end

	// Rounding: push the numerator away from zero by half the denominator.
	logic signed [ADJ_W-1:0] adjx_c, adjy_c, half_c;

	always_comb begin
		half_c = $signed(ADJ_W'(den_mag_s5 >> 1));
		adjx_c = numx_s5[NUM_W-1] ? ADJ_W'(numx_s5) - half_c : ADJ_W'(numx_s5) + half_c;
		adjy_c = numy_s5[NUM_W-1] ? ADJ_W'(numy_s5) - half_c : ADJ_W'(numy_s5) + half_c;
	end

	// Restoring division, one quotient bit per stage, most significant first.
	logic [ADJ_W-1:0]  dsh_c   [0:W];
	logic              gex_c   [0:W];
	logic              gey_c   [0:W];
	logic [ADJ_W-1:0]  remx_c  [0:W];
	logic [ADJ_W-1:0]  remy_c  [0:W];

	always_comb begin
		for (int i = 0; i <= W; i++) begin
			dsh_c[i]  = ADJ_W'(dv_dm_s[i]) << (W - i);
			gex_c[i]  = (dvx_rem_s[i] >= dsh_c[i]);
			gey_c[i]  = (dvy_rem_s[i] >= dsh_c[i]);
			remx_c[i] = gex_c[i] ? dvx_rem_s[i] - dsh_c[i] : dvx_rem_s[i];
			remy_c[i] = gey_c[i] ? dvy_rem_s[i] - dsh_c[i] : dvy_rem_s[i];
		end
	end

	// Divider entry takes magnitudes and quotient signs; later stages shift along.
	always_ff @(posedge clk) begin
		if (en) begin
			dv_status_s[0] <= status_s5;
			dv_dm_s[0]     <= den_mag_s5;
			dvx_neg_s[0]   <= adjx_c[ADJ_W-1] ^ den_neg_s5;
			dvy_neg_s[0]   <= adjy_c[ADJ_W-1] ^ den_neg_s5;
			dvx_rem_s[0]   <= adjx_c[ADJ_W-1] ? ADJ_W'(-adjx_c) : ADJ_W'(adjx_c);
			dvy_rem_s[0]   <= adjy_c[ADJ_W-1] ? ADJ_W'(-adjy_c) : ADJ_W'(adjy_c);
			dvx_q_s[0]     <= '0;
			dvy_q_s[0]     <= '0;
			for (int i = 0; i <= W; i++) begin
				dv_status_s[i+1] <= dv_status_s[i];
				dv_dm_s[i+1]     <= dv_dm_s[i];
				dvx_neg_s[i+1]   <= dvx_neg_s[i];
				dvy_neg_s[i+1]   <= dvy_neg_s[i];
				dvx_rem_s[i+1]   <= remx_c[i];
				dvy_rem_s[i+1]   <= remy_c[i];
				dvx_q_s[i+1]     <= {dvx_q_s[i][QUOT_W-2:0], gex_c[i]};
				dvy_q_s[i+1]     <= {dvy_q_s[i][QUOT_W-2:0], gey_c[i]};
			end
		end
	end

	// Output register: apply the quotient sign; the point reads 0 unless crossing.
	logic [QUOT_W-1:0] qx_c, qy_c;

	always_comb begin
		qx_c = dvx_neg_s[W+1] ? QUOT_W'(-dvx_q_s[W+1]) : dvx_q_s[W+1];
		qy_c = dvy_neg_s[W+1] ? QUOT_W'(-dvy_q_s[W+1]) : dvy_q_s[W+1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.status <= dv_status_s[W+1];
			if (dv_status_s[W+1] == STATUS_CROSS) begin
				out_q.cross_x <= W'(qx_c);
				out_q.cross_y <= W'(qy_c);
			end else begin
				out_q.cross_x <= '0;
				out_q.cross_y <= '0;
			end
		end
	end

endmodule
